FILE: rtl/core/cnlp_pkg.sv
// shared types, constants and codes of the comma number list parser
package cnlp_pkg;

   // fixed shape of the message and of the result values
   localparam int MAX_VALUES  = 16;
   localparam int FRAC_DIGITS = 7;
   localparam int LIMIT_CAP   = (MAX_VALUES < 16) ? MAX_VALUES : 16;
   localparam int CNT_W       = 5;
   localparam int SLOT_W      = 4;
   localparam int VAL_W       = 48;
   localparam int WHOLE_W     = 32;
   localparam int FRAC_Q      = 16;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 64;

   // fraction digits are kept scaled to FRAC_DIGITS places; the Q.16 part is
   // then one multiply by the reciprocal of 10**FRAC_DIGITS
   localparam longint unsigned FRAC_SCALE = 64'(10 ** FRAC_DIGITS);
   localparam int FRAC_W      = $clog2(FRAC_SCALE);
   localparam int RECIP_SHIFT = 40;
   localparam longint unsigned FRAC_RECIP_FULL =
      ((64'd1 << (RECIP_SHIFT + FRAC_Q)) + FRAC_SCALE - 64'd1) / FRAC_SCALE;
   localparam int FRAC_RECIP_W = $clog2(FRAC_RECIP_FULL + 64'd1);
   localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP = FRAC_RECIP_W'(FRAC_RECIP_FULL);
   localparam int PROD_W = FRAC_W + FRAC_RECIP_W;

   localparam logic [WHOLE_W-1:0] WHOLE_CAP = 32'h8000_0000;
   localparam logic [WHOLE_W-1:0] INT_MAX   = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0]   VAL_MIN   = 48'h8000_0000_0000;
   localparam logic [VAL_W-1:0]   VAL_MAX   = 48'h7FFF_FFFF_FFFF;

   // value kinds
   localparam logic [1:0] KIND_UNSIGNED = 2'd0;
   localparam logic [1:0] KIND_SIGNED   = 2'd1;
   localparam logic [1:0] KIND_DECIMAL  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_VALUE_KIND = 2'd0;
   localparam logic [1:0] REG_SKIP_VALUE = 2'd1;
   localparam logic [1:0] REG_MAX_COUNT  = 2'd2;

   localparam logic [1:0]       KIND_RESET  = KIND_SIGNED;
   localparam logic [VAL_W-1:0] SKIP_RESET  = '0;
   localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_START,
      PH_LEAD,
      PH_WHOLE,
      PH_SPAN,
      PH_FRAC,
      PH_SKIP,
      PH_IDLE,
      PH_OVER
   } phase_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [VAL_W-1:0] skip;
      logic [CNT_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic              is_end;
      logic              has_field;
      logic              status_only;
      logic              ovf;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  pad_next;
      logic [CNT_W-1:0]  pad_end;
      logic [CNT_W-1:0]  count;
   } meta_type;

   typedef struct packed {
      meta_type           meta;
      logic               tok;
      logic               neg;
      logic               dec;
      logic [WHOLE_W-1:0] whole;
      logic [FRAC_W-1:0]  frac;
   } evt_type;

   typedef struct packed {
      meta_type           meta;
      logic               tok;
      logic               neg;
      logic               dec;
      logic [WHOLE_W-1:0] whole_s;
      logic [FRAC_Q-1:0]  q;
   } calc_type;

   typedef struct packed {
      meta_type         meta;
      logic             tok;
      logic [VAL_W-1:0] value;
   } job_type;

   typedef struct packed {
      logic in_burst;
      logic padding;
   } emit_stat_type;

endpackage

FILE: rtl/core/cnlp_csr.sv
// configuration registers behind the apb-style port
module cnlp_csr
   import cnlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [1:0]       kind_ff;
   logic [VAL_W-1:0] skip_ff;
   logic [CNT_W-1:0] maxc_ff;
   logic [1:0]       kind_in;
   logic [VAL_W-1:0] skip_in;
   logic [CNT_W-1:0] maxc_in;
   logic [1:0]       reg_sel;
   logic             wr;

   assign pready  = 1'b1;
   assign reg_sel = paddr[ADDR_W-1:3];
   assign wr      = psel && penable && pwrite && pready;

   always_comb begin
      kind_in = kind_ff;
      skip_in = skip_ff;
      maxc_in = maxc_ff;
      if (wr) begin
         case (reg_sel)
            REG_VALUE_KIND: kind_in = pwdata[1:0];
            REG_SKIP_VALUE: skip_in = pwdata[VAL_W-1:0];
            REG_MAX_COUNT:  maxc_in = pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_VALUE_KIND: prdata = {{(DATA_W-2){1'b0}}, kind_ff};
         REG_SKIP_VALUE: prdata = {{(DATA_W-VAL_W){1'b0}}, skip_ff};
         REG_MAX_COUNT:  prdata = {{(DATA_W-CNT_W){1'b0}}, maxc_ff};
         default:        prdata = '0;
      endcase
   end

   // effective kind and count limit
   always_comb begin
      if (kind_ff == KIND_DECIMAL) begin
         cfg.kind = KIND_DECIMAL;
      end else if (kind_ff == KIND_UNSIGNED) begin
         cfg.kind = KIND_UNSIGNED;
      end else begin
         cfg.kind = KIND_SIGNED;
      end
      cfg.skip = skip_ff;
      if (maxc_ff == '0) begin
         cfg.limit = CNT_W'(1);
      end else if (maxc_ff > CNT_W'(LIMIT_CAP)) begin
         cfg.limit = CNT_W'(LIMIT_CAP);
      end else begin
         cfg.limit = maxc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_RESET;
         skip_ff <= SKIP_RESET;
         maxc_ff <= COUNT_RESET;
      end else begin
         kind_ff <= kind_in;
         skip_ff <= skip_in;
         maxc_ff <= maxc_in;
      end
   end

endmodule

FILE: rtl/core/cnlp_scan.sv
// per-character field tracker; posts one record per closed field or message end
module cnlp_scan
   import cnlp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic [7:0] req_char_code,
   input  logic     req_message_end,
   output logic     ev_valid,
   input  logic     ev_ready,
   output evt_type  ev
);

   phase_type          phase_ff, phase_in;
   logic [WHOLE_W-1:0] whole_ff, whole_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [2:0]         fdig_ff, fdig_in;
   logic               neg_ff, neg_in;
   logic               tok_ff, tok_in;
   logic [CNT_W-1:0]   done_ff, done_in;
   logic               pend_ff, pend_in;
   logic               ev_valid_ff, ev_valid_in;
   evt_type            ev_ff, ev_in;

   logic               accept;
   logic               is_dig;
   logic               is_minus;
   logic               is_dot;
   logic               dec;
   logic               num_set;
   logic               allowed;
   logic [3:0]         dval;
   logic               fire;
   logic               in_fld;
   logic [CNT_W-1:0]   done_new;
   evt_type            ev_new;

   function automatic logic is_field(input phase_type p);
      return p == PH_LEAD || p == PH_WHOLE || p == PH_SPAN || p == PH_FRAC || p == PH_SKIP;
   endfunction

   // saturating whole*10 + digit
   function automatic logic [WHOLE_W-1:0] add_whole(input logic [WHOLE_W-1:0] acc,
                                                    input logic [3:0] dig);
      logic [WHOLE_W+2:0] m;
      m = ({3'b0, acc} << 3) + ({3'b0, acc} << 1) + {{(WHOLE_W-1){1'b0}}, dig};
      if (m > (WHOLE_W+3)'(WHOLE_CAP)) begin
         return WHOLE_CAP;
      end
      return m[WHOLE_W-1:0];
   endfunction

   // weight of the fraction digit at position pos
   function automatic logic [FRAC_W-1:0] frac_place(input logic [2:0] pos);
      logic [FRAC_W-1:0] p;
      p = FRAC_W'(1);
      for (int i = 0; i < FRAC_DIGITS - 1; i++) begin
         if (i + int'(pos) < FRAC_DIGITS - 1) begin
            p = FRAC_W'(p * 10);
         end
      end
      return p;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !ev_valid_ff || ev_ready;
   assign ev_valid  = ev_valid_ff;
   assign ev        = ev_ff;

   assign is_dig   = req_char_code >= CH_ZERO && req_char_code <= CH_NINE;
   assign is_minus = req_char_code == CH_MINUS;
   assign is_dot   = req_char_code == CH_DOT;
   assign dec      = cfg.kind == KIND_DECIMAL;
   assign num_set  = is_dig || (is_minus && cfg.kind != KIND_UNSIGNED) || (is_dot && dec);
   assign allowed  = req_char_code == CH_SPACE || req_char_code == CH_COMMA || num_set;
   assign dval     = req_char_code[3:0];

   always_comb begin
      phase_in = phase_ff;
      whole_in = whole_ff;
      frac_in  = frac_ff;
      fdig_in  = fdig_ff;
      neg_in   = neg_ff;
      tok_in   = tok_ff;
      done_in  = done_ff;
      pend_in  = pend_ff;
      fire     = 1'b0;
      in_fld   = 1'b0;
      done_new = done_ff;
      ev_new   = '0;

      if (accept && !req_message_end) begin
         // field opening
         if (phase_in == PH_START) begin
            if (pend_ff || !allowed) begin
               phase_in = PH_IDLE;
            end else if (done_ff >= cfg.limit) begin
               phase_in = PH_OVER;
            end else begin
               whole_in = '0;
               frac_in  = '0;
               fdig_in  = '0;
               neg_in   = 1'b0;
               tok_in   = 1'b0;
               phase_in = PH_LEAD;
            end
         end
         if (!allowed) begin
            pend_in = 1'b1;
         end
         in_fld = is_field(phase_in);
         if (in_fld && req_char_code == CH_COMMA) begin
            fire                  = 1'b1;
            ev_new.meta.has_field = 1'b1;
            ev_new.meta.slot      = done_ff[SLOT_W-1:0];
            ev_new.tok            = tok_in;
            ev_new.neg            = neg_in;
            ev_new.dec            = dec;
            ev_new.whole          = whole_in;
            ev_new.frac           = frac_in;
            done_in               = done_ff + CNT_W'(1);
            phase_in              = PH_START;
         end else if (in_fld) begin
            case (phase_in)
               PH_LEAD: begin
                  if (req_char_code != CH_SPACE) begin
                     tok_in = num_set;
                     if (!num_set) begin
                        phase_in = PH_SKIP;
                     end else if (is_minus) begin
                        neg_in   = 1'b1;
                        phase_in = PH_WHOLE;
                     end else if (is_dot) begin
                        phase_in = PH_FRAC;
                     end else begin
                        whole_in = add_whole(whole_in, dval);
                        phase_in = PH_WHOLE;
                     end
                  end
               end
               PH_WHOLE: begin
                  if (is_dig) begin
                     whole_in = add_whole(whole_in, dval);
                  end else if (dec && is_minus) begin
                     phase_in = PH_SPAN;
                  end else if (dec && is_dot) begin
                     phase_in = PH_FRAC;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_SPAN: begin
                  if (!(is_dig || is_minus)) begin
                     phase_in = (dec && is_dot) ? PH_FRAC : PH_SKIP;
                  end
               end
               PH_FRAC: begin
                  if (!is_dig) begin
                     phase_in = PH_SKIP;
                  end else if (fdig_in < 3'(FRAC_DIGITS)) begin
                     frac_in = frac_in + FRAC_W'({{FRAC_W{1'b0}}, dval}
                                                 * {4'b0, frac_place(fdig_in)});
                     fdig_in = fdig_in + 3'd1;
                  end
               end
               default: ;
            endcase
         end
      end else if (accept) begin
         // message end: close any open field and size the padding run
         in_fld                  = is_field(phase_ff);
         done_new                = done_ff + CNT_W'(in_fld);
         fire                    = 1'b1;
         ev_new.meta.is_end      = 1'b1;
         ev_new.meta.has_field   = in_fld;
         ev_new.meta.slot        = done_ff[SLOT_W-1:0];
         ev_new.meta.ovf         = phase_ff == PH_OVER;
         ev_new.meta.pad_next    = done_new;
         ev_new.meta.pad_end     = (phase_ff == PH_OVER || done_new >= cfg.limit)
                                   ? done_new : cfg.limit;
         ev_new.meta.status_only = !in_fld && ev_new.meta.pad_end == done_new;
         ev_new.meta.count       = done_new;
         ev_new.tok              = tok_ff;
         ev_new.neg              = neg_ff;
         ev_new.dec              = dec;
         ev_new.whole            = whole_ff;
         ev_new.frac             = frac_ff;
         phase_in = PH_START;
         done_in  = '0;
         pend_in  = 1'b0;
         whole_in = '0;
         frac_in  = '0;
         fdig_in  = '0;
         neg_in   = 1'b0;
         tok_in   = 1'b0;
      end

      if (fire) begin
         ev_valid_in = 1'b1;
         ev_in       = ev_new;
      end else begin
         ev_valid_in = ev_valid_ff && !ev_ready;
         ev_in       = ev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         done_ff     <= '0;
         pend_ff     <= 1'b0;
         ev_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         done_ff     <= done_in;
         pend_ff     <= pend_in;
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      whole_ff <= whole_in;
      frac_ff  <= frac_in;
      fdig_ff  <= fdig_in;
      neg_ff   <= neg_in;
      tok_ff   <= tok_in;
      ev_ff    <= ev_in;
   end

endmodule

FILE: rtl/core/cnlp_value.sv
// signed whole part and fraction multiply, then q.16 combine and saturation
module cnlp_value
   import cnlp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  evt_type  in_evt,
   output logic     out_valid,
   input  logic     out_ready,
   output job_type  out_job
);

   logic       a_valid_ff, a_valid_in;
   calc_type   a_ff, a_in;

   logic [PROD_W-1:0]  prod;
   logic [VAL_W:0]     base;
   logic [VAL_W:0]     qx;
   logic [VAL_W:0]     sum;
   logic [VAL_W-1:0]   val;

   assign in_ready  = !a_valid_ff || out_ready;
   assign out_valid = a_valid_ff;

   // stage a: whole clamp or negate, fraction times reciprocal of 10**FRAC_DIGITS
   always_comb begin
      prod         = PROD_W'(in_evt.frac) * PROD_W'(FRAC_RECIP);
      a_in.meta    = in_evt.meta;
      a_in.tok     = in_evt.tok;
      a_in.neg     = in_evt.neg;
      a_in.dec     = in_evt.dec;
      a_in.q       = prod[RECIP_SHIFT+FRAC_Q-1:RECIP_SHIFT];
      if (in_evt.neg) begin
         a_in.whole_s = WHOLE_W'(0) - in_evt.whole;
      end else if (in_evt.whole > INT_MAX) begin
         a_in.whole_s = INT_MAX;
      end else begin
         a_in.whole_s = in_evt.whole;
      end
      a_valid_in = in_ready ? in_valid : a_valid_ff;
   end

   // combine: integers sign-extend, decimals whole*65536 +/- q clamped to 48 bits
   always_comb begin
      base = {{(VAL_W+1-WHOLE_W-FRAC_Q){a_ff.whole_s[WHOLE_W-1]}}, a_ff.whole_s, FRAC_Q'(0)};
      qx   = {{(VAL_W+1-FRAC_Q){1'b0}}, a_ff.q};
      sum  = a_ff.neg ? base - qx : base + qx;
      if (!a_ff.dec) begin
         val = {{(VAL_W-WHOLE_W){a_ff.whole_s[WHOLE_W-1]}}, a_ff.whole_s};
      end else if (sum[VAL_W] != sum[VAL_W-1]) begin
         val = sum[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         val = sum[VAL_W-1:0];
      end
      out_job.meta  = a_ff.meta;
      out_job.tok   = a_ff.tok;
      out_job.value = val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         a_ff <= a_in;
      end
   end

endmodule

FILE: rtl/core/cnlp_emit.sv
// result register and padding sequencer
module cnlp_emit
   import cnlp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  job_type             in_job,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_is_skipped,
   output logic [CNT_W-1:0]    rsp_values_received,
   output logic                rsp_overflowed,
   output logic                rsp_last_of_message,
   output emit_stat_type       stat
);

   logic     job_valid_ff, job_valid_in;
   job_type  job_ff, job_in;

   logic             last_beat;
   logic             beat_done;
   logic [CNT_W-1:0] pad_step;

   assign pad_step  = job_ff.meta.pad_next + CNT_W'(1);
   assign rsp_valid = job_valid_ff;
   assign beat_done = rsp_valid && rsp_ready;
   assign in_ready  = !job_valid_ff || (beat_done && last_beat);

   // beat select: field value first, then padding slots, or a lone status beat
   always_comb begin
      if (job_ff.meta.has_field) begin
         rsp_value      = job_ff.tok ? job_ff.value : cfg.skip;
         rsp_slot       = job_ff.meta.slot;
         rsp_is_skipped = !job_ff.tok;
         last_beat      = !job_ff.meta.is_end || job_ff.meta.pad_next == job_ff.meta.pad_end;
      end else if (job_ff.meta.status_only) begin
         rsp_value      = cfg.skip;
         rsp_slot       = '0;
         rsp_is_skipped = 1'b1;
         last_beat      = 1'b1;
      end else begin
         rsp_value      = cfg.skip;
         rsp_slot       = job_ff.meta.pad_next[SLOT_W-1:0];
         rsp_is_skipped = 1'b1;
         last_beat      = pad_step == job_ff.meta.pad_end;
      end
      rsp_last_of_message = job_ff.meta.is_end && last_beat;
      rsp_values_received = rsp_last_of_message ? job_ff.meta.count : '0;
      rsp_overflowed      = rsp_last_of_message && job_ff.meta.ovf;
      stat.in_burst       = job_valid_ff && job_ff.meta.is_end;
      stat.padding        = job_valid_ff && job_ff.meta.is_end && !job_ff.meta.has_field;
   end

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      if (in_valid && in_ready) begin
         job_in       = in_job;
         job_valid_in = 1'b1;
      end else if (beat_done) begin
         if (last_beat) begin
            job_valid_in = 1'b0;
         end else if (job_ff.meta.has_field) begin
            job_in.meta.has_field = 1'b0;
         end else begin
            job_in.meta.pad_next = pad_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

FILE: rtl/core/comma_number_list_parser_top.sv
// top level of the comma number list parser: csr block, scanner, value pipe, result stage
//
// takes one message character per req beat and splits the leading run of allowed
// characters (space, comma, digits, plus '-' for signed and '-' and '.' for decimal
// kind) into comma separated numbers. every field closed by a comma gives one rsp
// beat with its value; an empty field, or one whose first character is not a number
// character, gives skip_value with is_skipped set. integers saturate to signed 32
// bits, decimals come out as signed q.16 from up to seven fraction digits, truncated.
// a beat with req_message_end set closes the open field and then pads the remaining
// slots up to max_count with skip_value, unless more fields came than max_count
// allows; the last beat of a message carries values_received, overflowed and
// last_of_message. throughput is one character per clock while req_ready is high:
// the field state lives in a single register set updated every beat, and each
// closed field flows through three registered stages (field record, fraction
// multiply, result register) on its way to rsp. a message end yields from one up
// to max_count rsp beats at one per clock, while rsp_ready is high, from the result
// register; while that burst drains, req keeps being taken until the two
// registered stages in front of it are full, then req_ready drops. registers sit
// at byte addresses 0 (value_kind), 8 (skip_value) and 16 (max_count), 64-bit data,
// and should only be written while no results are outstanding.
module comma_number_list_parser_top
   import cnlp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // character beats
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_char_code,
   input  logic                    req_message_end,
   // result beats
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic [SLOT_W-1:0]       rsp_slot,
   output logic                    rsp_is_skipped,
   output logic [CNT_W-1:0]        rsp_values_received,
   output logic                    rsp_overflowed,
   output logic                    rsp_last_of_message,
   // register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   cfg_type        cfg;
   logic           ev_valid;
   logic           ev_ready;
   evt_type        ev;
   logic           job_valid;
   logic           job_ready;
   job_type        job;
   emit_stat_type  stat;

   // live configuration; kind 3 folds to signed, count limit clamped to 1..16
   cnlp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // per-character state machine; posts a record per field-closing comma or message end
   cnlp_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_message_end (req_message_end),
      .ev_valid        (ev_valid),
      .ev_ready        (ev_ready),
      .ev              (ev)
   );

   // fraction multiply stage then q.16 combine
   cnlp_value u_value (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ev_valid),
      .in_ready  (ev_ready),
      .in_evt    (ev),
      .out_valid (job_valid),
      .out_ready (job_ready),
      .out_job   (job)
   );

   // result register, expands a message end into its padding beats
   cnlp_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .in_valid            (job_valid),
      .in_ready            (job_ready),
      .in_job              (job),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_value           (rsp_value),
      .rsp_slot            (rsp_slot),
      .rsp_is_skipped      (rsp_is_skipped),
      .rsp_values_received (rsp_values_received),
      .rsp_overflowed      (rsp_overflowed),
      .rsp_last_of_message (rsp_last_of_message),
      .stat                (stat)
   );

`ifndef NO_ASSERTIONS
   // an overflowed message ends in a lone status beat
   a_ovf_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |->
         rsp_last_of_message && rsp_is_skipped && rsp_slot == '0)
      else $error("overflow flagged on a beat that is not a lone status beat");

   // count and overflow only travel on the final beat of a message
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_message |-> rsp_values_received == '0 && !rsp_overflowed)
      else $error("message status seen before the last beat");

   // inside an end burst the slots run back to back without gaps
   a_burst_slots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_message && stat.in_burst |=>
         rsp_valid && rsp_slot == $past(rsp_slot) + SLOT_W'(1))
      else $error("end burst slot sequence broken");

   // padding beats always carry the skip marker
   a_pad_skipped: assert property (@(posedge clock) disable iff (reset)
      stat.padding |-> rsp_valid && rsp_is_skipped)
      else $error("padding beat without skip marker");
`endif

endmodule

FILE: bench/comma_number_list_parser_top_tb.sv
// self-checking testbench of the comma number list parser top level
`timescale 1ns / 100ps

module comma_number_list_parser_top_tb;
   import cnlp_pkg::*;

   // value_kind 3 is outside the documented range and behaves as signed
   localparam logic [1:0] KIND_ALIAS = 2'd3;
   // cycles with no beat on either channel before the run is called hung
   localparam int WATCHDOG_LIMIT = 2000;
   // result pipe is three stages deep; give it some slack after the last beat
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS = 40;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [7:0]              req_char_code;
   logic                    req_message_end;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_value;
   logic [SLOT_W-1:0]       rsp_slot;
   logic                    rsp_is_skipped;
   logic [CNT_W-1:0]        rsp_values_received;
   logic                    rsp_overflowed;
   logic                    rsp_last_of_message;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [ADDR_W-1:0]       paddr;
   logic [DATA_W-1:0]       pwdata;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;

   comma_number_list_parser_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_char_code       (req_char_code),
      .req_message_end     (req_message_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_value           (rsp_value),
      .rsp_slot            (rsp_slot),
      .rsp_is_skipped      (rsp_is_skipped),
      .rsp_values_received (rsp_values_received),
      .rsp_overflowed      (rsp_overflowed),
      .rsp_last_of_message (rsp_last_of_message),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // one expected rsp beat
   typedef struct packed {
      logic [VAL_W-1:0]  value;
      logic [SLOT_W-1:0] slot;
      logic              skipped;
      logic [CNT_W-1:0]  count;
      logic              ovf;
      logic              last;
   } list_value_type;

   // one directed message together with the settings it runs under
   typedef struct {
      logic [1:0]       kind;
      logic [VAL_W-1:0] skip;
      logic [CNT_W-1:0] limit;
      string            text;
      logic [VAL_W-1:0] first;   // first beat of the end burst
      logic [CNT_W-1:0] count;
      logic             ovf;
   } demo_msg_type;

   list_value_type pending_values[$];
   logic [7:0]     msg_chars[$];
   demo_msg_type   demo_msgs[7];

   // register copies kept by the predictor
   logic [1:0]       cfg_kind;
   logic [VAL_W-1:0] cfg_skip;
   logic [CNT_W-1:0] cfg_limit;

   // parser state kept by the predictor
   phase_type    ph;
   logic [31:0]  whole;
   logic [23:0]  frac;
   int           fdig;
   bit           neg;
   bit           tok;
   int           done;
   bit           pref_end;

   // typed expectation of the message whose end beat is being sent
   bit               row_armed;
   logic [VAL_W-1:0] row_first;
   logic [CNT_W-1:0] row_count;
   logic             row_ovf;

   int mismatch_count;
   int stall_cycles;
   int tx_idle_pct;
   int rx_stall_pct;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic logic [1:0] eff_kind();
      return (cfg_kind == KIND_ALIAS) ? KIND_SIGNED : cfg_kind;
   endfunction

   // limit register clamped to 1..16 and to the build size
   function automatic int eff_limit();
      int lim;
      lim = int'(cfg_limit);
      if (lim < 1) lim = 1;
      if (lim > MAX_VALUES) lim = MAX_VALUES;
      if (lim > 16) lim = 16;
      return lim;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_number_char(input logic [7:0] c);
      if (is_digit(c)) return 1;
      if (c == CH_MINUS && eff_kind() != KIND_UNSIGNED) return 1;
      if (c == CH_DOT && eff_kind() == KIND_DECIMAL) return 1;
      return 0;
   endfunction

   function automatic void clear_number();
      whole = '0;
      frac  = '0;
      fdig  = 0;
      neg   = 0;
      tok   = 0;
   endfunction

   function automatic void add_whole_digit(input logic [7:0] c);
      longint m;
      m = longint'({32'd0, whole}) * 10 + (int'(c) - int'(CH_ZERO));
      whole = (m > 64'sh8000_0000) ? WHOLE_CAP : m[31:0];
   endfunction

   // skip value, or integer saturated to 32 bits, or q.16 to 48 bits
   function automatic logic [VAL_W-1:0] field_number();
      longint w;
      longint q;
      longint v;
      longint scale;
      if (!tok) return cfg_skip;
      w = longint'({32'd0, whole});
      if (neg) w = -w;
      else if (w > 64'sh7FFF_FFFF) w = 64'sh7FFF_FFFF;
      if (eff_kind() == KIND_DECIMAL) begin
         q = 0;
         if (fdig > 0) begin
            scale = 1;
            repeat (fdig) scale = scale * 10;
            q = (longint'({40'd0, frac}) * 65536) / scale;
         end
         v = w * 65536 + (neg ? -q : q);
         if (v < -(64'sh8000_0000_0000)) v = -(64'sh8000_0000_0000);
         if (v > 64'sh7FFF_FFFF_FFFF) v = 64'sh7FFF_FFFF_FFFF;
         w = v;
      end
      return w[VAL_W-1:0];
   endfunction

   function automatic void push_value(input logic [VAL_W-1:0] v, input int slot,
                                      input bit skipped, input bit last,
                                      input int cnt, input bit ov);
      list_value_type r;
      r.value   = v;
      r.slot    = slot[SLOT_W-1:0];
      r.skipped = skipped;
      r.count   = last ? cnt[CNT_W-1:0] : '0;
      r.ovf     = last ? ov : 1'b0;
      r.last    = last;
      pending_values.push_back(r);
   endfunction

   function automatic bit in_field();
      return ph >= PH_LEAD && ph <= PH_SKIP;
   endfunction

   function automatic void parse_field_char(input logic [7:0] c);
      bit dec;
      dec = eff_kind() == KIND_DECIMAL;
      if (c == CH_COMMA) begin
         push_value(field_number(), done, !tok, 0, 0, 0);
         done++;
         ph = PH_START;
         return;
      end
      case (ph)
         PH_LEAD: begin
            if (c != CH_SPACE) begin
               tok = is_number_char(c);
               if (!tok) ph = PH_SKIP;
               else if (c == CH_MINUS) begin
                  neg = 1;
                  ph  = PH_WHOLE;
               end else if (c == CH_DOT) ph = PH_FRAC;
               else begin
                  add_whole_digit(c);
                  ph = PH_WHOLE;
               end
            end
         end
         PH_WHOLE: begin
            if (is_digit(c)) add_whole_digit(c);
            else if (dec && c == CH_MINUS) ph = PH_SPAN;
            else if (dec && c == CH_DOT) ph = PH_FRAC;
            else ph = PH_SKIP;
         end
         PH_SPAN: begin
            // decimal kind walks over dashes and digits up to the point
            if (!(is_digit(c) || c == CH_MINUS))
               ph = (dec && c == CH_DOT) ? PH_FRAC : PH_SKIP;
         end
         PH_FRAC: begin
            if (!is_digit(c)) ph = PH_SKIP;
            else if (fdig < FRAC_DIGITS) begin
               frac = 24'(frac * 10 + (int'(c) - int'(CH_ZERO)));
               fdig++;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      bit allowed;
      allowed = c == CH_SPACE || c == CH_COMMA || is_number_char(c);
      if (ph == PH_START) begin
         if (pref_end || !allowed) ph = PH_IDLE;
         else if (done >= eff_limit()) ph = PH_OVER;
         else begin
            clear_number();
            ph = PH_LEAD;
         end
      end
      if (!allowed) pref_end = 1;
      if (in_field()) parse_field_char(c);
   endfunction

   // closes the open field, pads to the limit and tags the last beat
   task automatic parse_message_end();
      int nd;
      int npad;
      int i;
      bit ov;
      bit open;
      logic [VAL_W-1:0] first;
      open  = in_field();
      nd    = done + (open ? 1 : 0);
      ov    = ph == PH_OVER;
      npad  = (!ov && eff_limit() > nd) ? eff_limit() - nd : 0;
      first = open ? field_number() : cfg_skip;
      if (open) push_value(first, done, !tok, npad == 0, nd, ov);
      for (i = nd; i < nd + npad; i++)
         push_value(cfg_skip, i, 1, i == nd + npad - 1, nd, ov);
      // nothing left to emit: a lone status beat
      if (!open && npad == 0) push_value(cfg_skip, 0, 1, 1, nd, ov);
      if (row_armed) begin
         row_armed = 0;
         if (first !== row_first)
            report_mismatch("directed first value", 64'(first), 64'(row_first));
         if (nd[CNT_W-1:0] !== row_count)
            report_mismatch("directed count", 64'(nd), 64'(row_count));
         if (ov !== row_ovf) report_mismatch("directed overflow", 64'(ov), 64'(row_ovf));
      end
      ph       = PH_START;
      done     = 0;
      pref_end = 0;
      clear_number();
   endtask

   // ---------------------------------------------------------------- monitors

   // predict on every accepted character beat
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (req_message_end) parse_message_end();
         else parse_char(req_char_code);
      end
   end

   // compare every accepted result beat with the oldest prediction
   always @(posedge clock) begin
      list_value_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            report_mismatch("result with none expected", 64'(rsp_value), '0);
         end else begin
            want = pending_values.pop_front();
            if (rsp_value !== want.value)
               report_mismatch("value", 64'(rsp_value), 64'(want.value));
            if (rsp_slot !== want.slot)
               report_mismatch("slot", 64'(rsp_slot), 64'(want.slot));
            if (rsp_is_skipped !== want.skipped)
               report_mismatch("is_skipped", 64'(rsp_is_skipped), 64'(want.skipped));
            if (rsp_values_received !== want.count)
               report_mismatch("values_received", 64'(rsp_values_received),
                               64'(want.count));
            if (rsp_overflowed !== want.ovf)
               report_mismatch("overflowed", 64'(rsp_overflowed), 64'(want.ovf));
            if (rsp_last_of_message !== want.last)
               report_mismatch("last_of_message", 64'(rsp_last_of_message),
                               64'(want.last));
         end
      end
   end

   // receiver side: random back pressure per the current phase
   always @(posedge clock) begin
      rsp_ready <= (rx_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_stall_pct);
   end

   // hang detection: any beat or register access restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // one character beat; valid stays up across back-to-back beats
   task automatic send_char(input logic [7:0] c, input bit is_end);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_code   <= c;
      req_message_end <= is_end;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_message();
      foreach (msg_chars[k]) send_char(msg_chars[k], 1'b0);
      // char_code on the end beat is a don't care, so randomize it
      send_char(8'($urandom_range(255)), 1'b1);
   endtask

   // quiet point: all predicted beats out and the pipe settled
   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the predictor take the last accepted beat first
      @(posedge clock);
      while (pending_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup then access phase, register written when the access completes
   task automatic csr_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_VALUE_KIND: cfg_kind  = data[1:0];
         REG_SKIP_VALUE: cfg_skip  = data[VAL_W-1:0];
         REG_MAX_COUNT:  cfg_limit = data[CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // only registers that change are written, so reset values get exercised
   task automatic apply_config(input logic [1:0] kind, input logic [VAL_W-1:0] skip,
                               input logic [CNT_W-1:0] lim);
      wait_drained();
      if (kind != cfg_kind) csr_write(REG_VALUE_KIND, {62'd0, kind});
      if (skip != cfg_skip) csr_write(REG_SKIP_VALUE, {{16{skip[VAL_W-1]}}, skip});
      if (lim != cfg_limit) csr_write(REG_MAX_COUNT, {59'd0, lim});
   endtask

   // mostly well formed lists with random numbers, some noise and broken fields
   function automatic void build_message();
      int    nf;
      int    lim;
      int    n;
      int    j;
      bit    dec_k;
      string big;
      big   = "2147483648";
      dec_k = eff_kind() == KIND_DECIMAL;
      lim   = eff_limit();
      msg_chars.delete();
      if ($urandom_range(99) < 8) begin
         n = $urandom_range(1, 6);
         repeat (n) msg_chars.push_back(8'($urandom_range(255)));
         return;
      end
      // now and then more fields than the limit takes
      if ($urandom_range(9) == 0) nf = lim + $urandom_range(1, 3);
      else nf = $urandom_range(0, (lim < 4) ? lim : 4);
      for (j = 0; j < nf; j++) begin
         if (j > 0) msg_chars.push_back(CH_COMMA);
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) msg_chars.push_back(CH_SPACE);
         case ($urandom_range(9))
            0: ;
            1: msg_chars.push_back(8'($urandom_range(255)));
            2: begin
               // right at the 32-bit magnitude cap
               if ($urandom_range(1)) msg_chars.push_back(CH_MINUS);
               for (n = 0; n < big.len(); n++) msg_chars.push_back(big[n]);
               if (dec_k && $urandom_range(1)) begin
                  msg_chars.push_back(CH_DOT);
                  msg_chars.push_back(CH_NINE);
               end
            end
            default: begin
               if ((eff_kind() != KIND_UNSIGNED && $urandom_range(2) == 0) ||
                   $urandom_range(11) == 0)
                  msg_chars.push_back(CH_MINUS);
               n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
               repeat (n) msg_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
               if (dec_k) begin
                  if ($urandom_range(5) == 0) begin
                     msg_chars.push_back(CH_MINUS);
                     repeat ($urandom_range(0, 2))
                        msg_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
                  end
                  if ($urandom_range(1)) begin
                     msg_chars.push_back(CH_DOT);
                     repeat ($urandom_range(0, 9))
                        msg_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
                  end
               end else if ($urandom_range(11) == 0) begin
                  msg_chars.push_back(CH_DOT);
               end
               if ($urandom_range(7) == 0) msg_chars.push_back(8'($urandom_range(255)));
            end
         endcase
      end
      if ($urandom_range(5) == 0) msg_chars.push_back(CH_COMMA);
      if ($urandom_range(5) == 0)
         repeat ($urandom_range(1, 2)) msg_chars.push_back(8'($urandom_range(255)));
   endfunction

   // ---------------------------------------------------------------- sequence

   initial begin
      logic [1:0]       kind;
      logic [VAL_W-1:0] skip;
      logic [CNT_W-1:0] lim;
      int               sent;
      int               p;
      int               k;

      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_char_code   = '0;
      req_message_end = 1'b0;
      rsp_ready       = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      mismatch_count  = 0;
      stall_cycles    = 0;
      tx_idle_pct     = 0;
      rx_stall_pct    = 0;
      row_armed       = 0;
      cfg_kind        = KIND_RESET;
      cfg_skip        = SKIP_RESET;
      cfg_limit       = COUNT_RESET;
      ph              = PH_START;
      done            = 0;
      pref_end        = 0;
      clear_number();

      // reset settings first: a negative integer
      demo_msgs[0] = '{KIND_SIGNED, 48'h0, 5'd16, "-5", 48'hFFFF_FFFF_FFFB, 5'd1, 1'b0};
      // limit of one hit at the next field: overflow and a lone status beat
      demo_msgs[1] = '{KIND_UNSIGNED, 48'h7FFF_FFFF_FFFF, 5'd1, "1,2",
                       48'h7FFF_FFFF_FFFF, 5'd1, 1'b1};
      // negative fraction with no whole digits
      demo_msgs[2] = '{KIND_DECIMAL, 48'h8000_0000_0000, 5'd2, "-.5",
                       48'hFFFF_FFFF_8000, 5'd1, 1'b0};
      // kind 3 and limit 0, message outside the allowed set from the start
      demo_msgs[3] = '{KIND_ALIAS, 48'h8000_0000_0000, 5'd0, "a",
                       48'h8000_0000_0000, 5'd0, 1'b0};
      // leading space and a point with no fraction digits
      demo_msgs[4] = '{KIND_DECIMAL, 48'h0, 5'd16, " 2.", 48'h0000_0002_0000, 5'd1, 1'b0};
      // broken number closed by a comma, then the prefix ends
      demo_msgs[5] = '{KIND_SIGNED, 48'h0, 5'd16, "1-2,x", 48'h0, 5'd1, 1'b0};
      // trailing comma opens no field
      demo_msgs[6] = '{KIND_UNSIGNED, 48'h5, 5'd3, "4,", 48'h5, 5'd1, 1'b0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed messages
      for (k = 0; k < 7; k++) begin
         apply_config(demo_msgs[k].kind, demo_msgs[k].skip, demo_msgs[k].limit);
         msg_chars.delete();
         for (p = 0; p < demo_msgs[k].text.len(); p++)
            msg_chars.push_back(demo_msgs[k].text[p]);
         foreach (msg_chars[j]) send_char(msg_chars[j], 1'b0);
         row_first = demo_msgs[k].first;
         row_count = demo_msgs[k].count;
         row_ovf   = demo_msgs[k].ovf;
         row_armed = 1;
         send_char(8'($urandom_range(255)), 1'b1);
      end

      // random phases: kind, skip value, limit and idling all move around
      for (p = 0; p < 8; p++) begin
         case (p % 4)
            0: kind = KIND_UNSIGNED;
            1: kind = KIND_SIGNED;
            2: kind = KIND_DECIMAL;
            default: kind = KIND_ALIAS;
         endcase
         case (p)
            0: skip = 48'h8000_0000_0000;
            1: skip = 48'h7FFF_FFFF_FFFF;
            2: skip = 48'h0;
            default: skip = {$urandom, $urandom};
         endcase
         case (p)
            0: lim = 5'd1;
            1: lim = 5'd16;
            2: lim = 5'd0;
            3: lim = 5'd31;
            4: lim = 5'($urandom_range(2, 6));
            5: lim = 5'd16;
            6: lim = 5'($urandom_range(1, 16));
            default: lim = 5'd2;
         endcase
         apply_config(kind, skip, lim);
         case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
            default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_message();
            send_message();
            sent += msg_chars.size() + 1;
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
